### rtl/core/djem_pkg.sv
// ----------------------------------------------------------------------------
// djem_pkg
// Shared types and constants for the dispenser channel jam/empty monitor.
// ----------------------------------------------------------------------------
package djem_pkg;

    localparam int CH_NUM   = 5;
    localparam int CNT_W    = 16;
    localparam int DEB_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [DEB_W-1:0] DEBOUNCE_RST = DEB_W'(3);
    localparam logic [CNT_W-1:0] JAM_RST      = CNT_W'(400);
    localparam logic [CNT_W-1:0] EMPTY_RST    = CNT_W'(12000);

    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_RUN   = 3'd1,
        REQ_AUTO  = 3'd2,
        REQ_STOP  = 3'd3,
        REQ_STOCK = 3'd4
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_JAM      = 2'd1,
        CFG_EMPTY    = 2'd2
    } cfg_idx_t;

    // per-channel status flags
    typedef struct packed {
        logic run;
        logic passed;
        logic jam;
        logic empty;
        logic stock;
    } ch_bits_t;

    // limits shared by all channels
    typedef struct packed {
        logic [DEB_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] jam_ticks;
        logic [CNT_W-1:0] empty_ticks;
    } limits_t;

endpackage

### rtl/core/dispenser_channel_jam_empty_monitor_core.sv
// ----------------------------------------------------------------------------
// dispenser_channel_jam_empty_monitor_core
// Five-channel dispenser exit monitor with jam and empty detection.
// ----------------------------------------------------------------------------
// Pipeline: the input transfer is captured in the input register, then one pass
//   of channel logic goes into the result register, which holds the result.
// Throughput: one item per cycle unless the output stalls; all channels in parallel.
// Reset: asynchronous, active low; flags clear, stock mask all ones, limits
//   return to 3 / 400 / 12000.
module dispenser_channel_jam_empty_monitor_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [djem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [djem_pkg::CFG_DAT_W-1:0] cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // sense_bits[4:0], select_gate[5],
                                                         // channel[8:6], stock_load[13:9]
    input  logic [2:0]                    s_axis_tuser,  // req_type
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata   // run_mask[4:0], passed_mask[9:5],
                                                         // jam_error_mask[14:10],
                                                         // empty_error_mask[19:15],
                                                         // stock_mask[24:20], led_mask[29:25],
                                                         // auto_none[30]
);
    import djem_pkg::*;

    limits_t limits_reg;

    logic              in_valid_reg;
    req_t              req_reg;
    logic [CH_NUM-1:0] sense_reg;
    logic              gate_reg;
    logic [2:0]        chan_reg;
    logic [CH_NUM-1:0] load_reg;

    logic [CH_NUM-1:0] run_reg, run_next;
    logic [CH_NUM-1:0] passed_reg, passed_next;
    logic [CH_NUM-1:0] jam_reg, jam_next;
    logic [CH_NUM-1:0] empty_reg, empty_next;
    logic [CH_NUM-1:0] stock_reg, stock_next;
    logic [CH_NUM-1:0] lamp_reg, lamp_next;
    logic              none_next;

    logic              out_valid_reg;
    logic [31:0]       out_data_reg;

    logic              advance;
    logic              tick_en;
    logic [CH_NUM-1:0] tick_run, tick_passed, tick_jam, tick_empty, tick_stock;
    logic [CH_NUM-1:0] lowest_stock;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign tick_en       = advance && (req_reg == REQ_TICK) && !gate_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.debounce_ticks <= DEBOUNCE_RST;
            limits_reg.jam_ticks      <= JAM_RST;
            limits_reg.empty_ticks    <= EMPTY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: limits_reg.debounce_ticks <= cfg_data[DEB_W-1:0];
                CFG_JAM:      limits_reg.jam_ticks      <= cfg_data[CNT_W-1:0];
                CFG_EMPTY:    limits_reg.empty_ticks    <= cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            req_reg   <= req_t'(s_axis_tuser);
            sense_reg <= s_axis_tdata[4:0];
            gate_reg  <= s_axis_tdata[5];
            chan_reg  <= s_axis_tdata[8:6];
            load_reg  <= s_axis_tdata[13:9];
        end
    end

    // channel tick logic
    for (genvar i = 0; i < CH_NUM; i++)
    begin : g_chan
        ch_bits_t cur_bits;
        ch_bits_t nxt_bits;

        assign cur_bits = '{run: run_reg[i], passed: passed_reg[i], jam: jam_reg[i],
                            empty: empty_reg[i], stock: stock_reg[i]};

        djem_chan u_chan (
            .clk     (clk),
            .rst_n   (rst_n),
            .tick_en (tick_en),
            .sense   (sense_reg[i]),
            .limits  (limits_reg),
            .cur     (cur_bits),
            .nxt     (nxt_bits)
        );

        assign tick_run[i]    = nxt_bits.run;
        assign tick_passed[i] = nxt_bits.passed;
        assign tick_jam[i]    = nxt_bits.jam;
        assign tick_empty[i]  = nxt_bits.empty;
        assign tick_stock[i]  = nxt_bits.stock;
    end

    // isolate lowest stocked channel
    assign lowest_stock = stock_reg & (~stock_reg + CH_NUM'(1));

    always_comb
    begin
        run_next    = run_reg;
        passed_next = passed_reg;
        jam_next    = jam_reg;
        empty_next  = empty_reg;
        stock_next  = stock_reg;
        lamp_next   = lamp_reg;
        none_next   = 1'b0;
        case (req_reg)
            REQ_TICK:
            begin
                if (!gate_reg)
                begin
                    run_next    = tick_run;
                    passed_next = tick_passed;
                    jam_next    = tick_jam;
                    empty_next  = tick_empty;
                    stock_next  = tick_stock;
                end
            end
            REQ_RUN:
            begin
                if (chan_reg < 3'(CH_NUM))
                begin
                    run_next = run_reg | (CH_NUM'(1) << chan_reg);
                end
            end
            REQ_AUTO:
            begin
                if (stock_reg == '0)
                begin
                    none_next = 1'b1;
                end
                else
                begin
                    lamp_next = lowest_stock;
                    run_next  = run_reg | lowest_stock;
                end
            end
            REQ_STOP:  run_next = '0;
            REQ_STOCK: stock_next = load_reg;
            default:   ;
        endcase
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            passed_reg    <= '0;
            jam_reg       <= '0;
            empty_reg     <= '0;
            stock_reg     <= '1;
            lamp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                run_reg    <= run_next;
                passed_reg <= passed_next;
                jam_reg    <= jam_next;
                empty_reg  <= empty_next;
                stock_reg  <= stock_next;
                lamp_reg   <= lamp_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {1'b0, none_next, lamp_next, stock_next, empty_next,
                             jam_next, passed_next, run_next};
        end
    end

    a_lamp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(lamp_reg))
        else $error("lamp mask not one-hot");

    a_empty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((empty_reg & $past(empty_reg)) == $past(empty_reg)))
        else $error("empty error cleared");

    a_none_no_stock: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[30]) |-> (out_data_reg[24:20] == '0))
        else $error("auto_none with stocked channel");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("accepted transfer lost");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(run_reg) && $stable(stock_reg) && $stable(jam_reg)))
        else $error("state changed without advance");

endmodule

### rtl/core/djem_chan.sv
// ----------------------------------------------------------------------------
// djem_chan
// One dispenser channel: actuated and idle-run counters plus next flag logic.
// ----------------------------------------------------------------------------
module djem_chan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick_en,
    input  logic              sense,
    input  djem_pkg::limits_t limits,
    input  djem_pkg::ch_bits_t cur,
    output djem_pkg::ch_bits_t nxt
);
    import djem_pkg::*;

    logic [CNT_W-1:0] act_count_reg, act_count_next;
    logic [CNT_W-1:0] idle_count_reg, idle_count_next;
    logic [CNT_W:0]   act_inc;
    logic [CNT_W:0]   idle_inc;

    assign act_inc  = {1'b0, act_count_reg} + (CNT_W+1)'(1);
    assign idle_inc = {1'b0, idle_count_reg} + (CNT_W+1)'(1);

    always_comb
    begin
        nxt             = cur;
        act_count_next  = act_count_reg;
        idle_count_next = idle_count_reg;
        if (sense)
        begin
            // released
            act_count_next = '0;
            if (cur.run)
            begin
                if (cur.passed)
                begin
                    nxt.run = 1'b0;
                end
                else if (idle_inc > {1'b0, limits.empty_ticks})
                begin
                    idle_count_next = limits.empty_ticks;
                    nxt.stock       = 1'b0;
                    nxt.run         = 1'b0;
                    nxt.empty       = 1'b1;
                end
                else
                begin
                    idle_count_next = idle_inc[CNT_W-1:0];
                end
            end
            else
            begin
                idle_count_next = '0;
            end
            nxt.passed = 1'b0;
            nxt.jam    = 1'b0;
        end
        else
        begin
            // actuated
            idle_count_next = '0;
            if (act_inc > {1'b0, limits.jam_ticks})
            begin
                act_count_next = limits.jam_ticks;
                nxt.jam        = 1'b1;
                nxt.run        = 1'b0;
            end
            else
            begin
                act_count_next = act_inc[CNT_W-1:0];
                if (act_inc > (CNT_W+1)'(limits.debounce_ticks))
                begin
                    nxt.passed = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_count_reg  <= '0;
            idle_count_reg <= '0;
        end
        else if (tick_en)
        begin
            act_count_reg  <= act_count_next;
            idle_count_reg <= idle_count_next;
        end
    end

endmodule

### verif/dispenser_channel_jam_empty_monitor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dispenser_channel_jam_empty_monitor_core_tb
// Self-checking bench for the five-channel dispenser exit monitor. Requests go
// in over the input stream. A local model of the channel flags, counters and
// limits predicts every status word, and each output transfer is compared
// field by field against the oldest prediction. The bench applies random
// stalls on both streams, one long output hold-off and several limit settings.
// ----------------------------------------------------------------------------
module dispenser_channel_jam_empty_monitor_core_tb;

    import djem_pkg::*;

    localparam int HOLD_CYCLES     = 150;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DRAIN_GAP       = 4;
    localparam int END_CYCLES      = 10;
    localparam int IDLE_PCT        = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam logic [2:0]           REQ_SPARE     = 3'd5;

    // status word as it leaves the block, run_mask in the low bits
    typedef struct packed {
        logic       auto_none;
        logic [4:0] led;
        logic [4:0] stock;
        logic [4:0] empty;
        logic [4:0] jam;
        logic [4:0] passed;
        logic [4:0] run;
    } status_t;

    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [CFG_DAT_W-1:0] cfg_data       = '0;
    logic                 s_axis_tvalid  = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata   = '0;
    logic [2:0]           s_axis_tuser   = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready  = 1'b0;
    logic [31:0]          m_axis_tdata;

    // model of the block
    logic [4:0] run_st    = '0;
    logic [4:0] passed_st = '0;
    logic [4:0] jam_st    = '0;
    logic [4:0] empty_st  = '0;
    logic [4:0] stock_st  = 5'h1f;
    logic [4:0] lamp_st   = '0;
    int         act_cnt  [CH_NUM] = '{default: 0};
    int         idle_cnt [CH_NUM] = '{default: 0};
    int         lim_debounce = 3;
    int         lim_jam      = 400;
    int         lim_empty    = 12000;

    status_t    expected_status[$];
    int         fail_count = 0;
    logic       quiet      = 1'b0;
    logic [7:0] hold_token = '0;
    logic [7:0] hold_seen;
    int         hold_left;
    int         stall_cycles;
    logic [4:0] sw_level   = 5'h1f;

    dispenser_channel_jam_empty_monitor_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one request through the channel model; returns the status after it
    function automatic status_t monitor_step(input logic [2:0] req, input logic [4:0] sense,
                                             input logic gate, input logic [2:0] chan,
                                             input logic [4:0] load);
        status_t res;
        logic    none;
        none = 1'b0;
        case (req)
            REQ_TICK:
            begin
                if (!gate)
                begin
                    for (int i = 0; i < CH_NUM; i++)
                    begin
                        if (sense[i])
                        begin
                            act_cnt[i] = 0;
                            if (run_st[i])
                            begin
                                if (passed_st[i])
                                    run_st[i] = 1'b0;
                                else if (idle_cnt[i] + 1 > lim_empty)
                                begin
                                    idle_cnt[i] = lim_empty;
                                    stock_st[i] = 1'b0;
                                    run_st[i]   = 1'b0;
                                    empty_st[i] = 1'b1;
                                end
                                else
                                    idle_cnt[i] = idle_cnt[i] + 1;
                            end
                            else
                                idle_cnt[i] = 0;
                            passed_st[i] = 1'b0;
                            jam_st[i]    = 1'b0;
                        end
                        else
                        begin
                            idle_cnt[i] = 0;
                            if (act_cnt[i] + 1 > lim_jam)
                            begin
                                act_cnt[i] = lim_jam;
                                jam_st[i]  = 1'b1;
                                run_st[i]  = 1'b0;
                            end
                            else
                            begin
                                act_cnt[i] = act_cnt[i] + 1;
                                if (act_cnt[i] > lim_debounce)
                                    passed_st[i] = 1'b1;
                            end
                        end
                    end
                end
            end
            REQ_RUN:
            begin
                if (chan < CH_NUM)
                    run_st[chan] = 1'b1;
            end
            REQ_AUTO:
            begin
                none = 1'b1;
                for (int i = 0; i < CH_NUM; i++)
                begin
                    if (none && stock_st[i])
                    begin
                        lamp_st    = '0;
                        lamp_st[i] = 1'b1;
                        run_st[i]  = 1'b1;
                        none       = 1'b0;
                    end
                end
            end
            REQ_STOP:  run_st = '0;
            REQ_STOCK: stock_st = load;
            default: ;
        endcase
        res.run       = run_st;
        res.passed    = passed_st;
        res.jam       = jam_st;
        res.empty     = empty_st;
        res.stock     = stock_st;
        res.led       = lamp_st;
        res.auto_none = none;
        return res;
    endfunction

    // present one request; returns at the edge where it transfers
    task automatic send_item(input logic [2:0] req, input logic [4:0] sense, input logic gate,
                             input logic [2:0] chan, input logic [4:0] load);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {2'b00, load, chan, gate, sense};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_status.push_back(monitor_step(req, sense, gate, chan, load));
    endtask

    // sender stops and waits for every pending status word
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // leaves cfg_valid high; callers lower it after the last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DEBOUNCE: lim_debounce = int'(data & 16'h03ff);
            CFG_JAM:      lim_jam      = int'(data);
            CFG_EMPTY:    lim_empty    = int'(data);
            default: ;
        endcase
    endtask

    task automatic set_limits(input int deb, input int jam, input int emp);
        wait_drained();
        cfg_write(CFG_DEBOUNCE, deb[CFG_DAT_W-1:0]);
        cfg_write(CFG_JAM, jam[CFG_DAT_W-1:0]);
        cfg_write(CFG_EMPTY, emp[CFG_DAT_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // mostly switch patterns that persist over ticks, so counters reach their limits
    task automatic send_random_item();
        int         r;
        logic [2:0] chan;
        logic [4:0] load;
        r    = int'($urandom_range(0, 99));
        chan = 3'($urandom_range(0, 7));
        load = 5'($urandom_range(0, 31));
        if (r < 62)
        begin
            for (int i = 0; i < CH_NUM; i++)
                if ($urandom_range(0, 99) < 12)
                    sw_level[i] = ~sw_level[i];
            send_item(REQ_TICK, sw_level, $urandom_range(0, 99) < 8, chan, load);
        end
        else if (r < 74)
        begin
            chan = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            send_item(REQ_RUN, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), chan, load);
        end
        else if (r < 82)
            send_item(REQ_AUTO, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), chan, load);
        else if (r < 86)
            send_item(REQ_STOP, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), chan, load);
        else if (r < 91)
        begin
            if ($urandom_range(0, 3) != 0)
                load = load | 5'h11;
            send_item(REQ_STOCK, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), chan,
                      load);
        end
        else if (r < 94)
            send_item(3'($urandom_range(5, 7)), 5'($urandom_range(0, 31)),
                      1'($urandom_range(0, 1)), chan, load);
        else
            send_item(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                      1'($urandom_range(0, 1)), chan, load);
    endtask

    // a reserved request code, run, auto run, stop all, stock load, gated tick
    task automatic test_request_types();
        send_item(REQ_SPARE, 5'h1f, 1'b1, 3'd7, 5'h1f);
        send_item(REQ_RUN, 5'h00, 1'b0, 3'd0, 5'h00);
        send_item(REQ_RUN, 5'h1f, 1'b1, 3'd4, 5'h1f);
        send_item(REQ_RUN, 5'h00, 1'b0, 3'd7, 5'h00);
        send_item(REQ_TICK, 5'h00, 1'b1, 3'd0, 5'h00);
        send_item(REQ_STOP, 5'h1f, 1'b1, 3'd7, 5'h1f);
        send_item(REQ_STOCK, 5'h00, 1'b0, 3'd0, 5'b10100);
        send_item(REQ_AUTO, 5'h1f, 1'b0, 3'd0, 5'h00);
        send_item(REQ_STOCK, 5'h1f, 1'b0, 3'd0, 5'h00);
        // no stock left: no channel starts, lamp stays
        send_item(REQ_AUTO, 5'h00, 1'b1, 3'd0, 5'h00);
        send_item(REQ_STOCK, 5'h00, 1'b0, 3'd0, 5'h1f);
    endtask

    // passage stop, empty, jam and release, then limits of zero
    task automatic test_channel_faults();
        wait_drained();
        cfg_write(CFG_IDX_SPARE, 16'hffff);
        cfg_valid <= 1'b0;
        set_limits(1, 3, 2);
        send_item(REQ_RUN, 5'h00, 1'b0, 3'd0, 5'h00);
        send_item(REQ_TICK, 5'h1e, 1'b0, 3'd0, 5'h00);
        send_item(REQ_TICK, 5'h1e, 1'b0, 3'd0, 5'h00);
        send_item(REQ_TICK, 5'h1f, 1'b0, 3'd0, 5'h00);
        send_item(REQ_RUN, 5'h00, 1'b0, 3'd1, 5'h00);
        repeat (3) send_item(REQ_TICK, 5'h1f, 1'b0, 3'd0, 5'h00);
        repeat (4) send_item(REQ_TICK, 5'h00, 1'b0, 3'd0, 5'h00);
        set_limits(0, 0, 0);
        send_item(REQ_RUN, 5'h00, 1'b0, 3'd1, 5'h00);
        send_item(REQ_TICK, 5'h1f, 1'b0, 3'd0, 5'h00);
        send_item(REQ_TICK, 5'h00, 1'b0, 3'd0, 5'h00);
        set_limits(0, 0, 0);
        send_item(REQ_STOCK, 5'h1f, 1'b0, 3'd0, 5'h1f);
    endtask

    // random traffic under several small limit sets; one phase runs without stalls
    task automatic test_random_limits();
        for (int p = 0; p < 5; p++)
        begin
            if (p == 0)
                set_limits(2, 12, 8);
            else
                set_limits($urandom_range(0, 6), $urandom_range(1, 25), $urandom_range(1, 25));
            quiet <= (p == 2);
            repeat (110) send_random_item();
        end
        quiet <= 1'b0;
    endtask

    task automatic test_limit_extremes();
        set_limits(1023, 65535, 65535);
        repeat (40) send_random_item();
        set_limits(0, 1, 1);
        repeat (40) send_random_item();
    endtask

    // long hold-off on the output while requests keep coming
    task automatic test_output_stall();
        set_limits(3, 15, 10);
        hold_token <= hold_token + 1'b1;
        repeat (100) send_random_item();
    endtask

    task automatic test_drain_pause();
        repeat (40) send_random_item();
        wait_drained();
        repeat (40) send_random_item();
    endtask

    // output side flow control
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_seen     <= '0;
            hold_left     <= 0;
        end
        else if (hold_seen != hold_token)
        begin
            hold_seen     <= hold_token;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // compare each status word with the oldest prediction
    always @(posedge clk)
    begin
        status_t     want;
        logic [31:0] exp_word;
        int          lo;
        logic [4:0]  fmask;
        string       names [8];
        names = '{"run_mask", "passed_mask", "jam_error_mask", "empty_error_mask",
                  "stock_mask", "led_mask", "auto_none", "pad"};
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_status.size() == 0)
            begin
                $error("status transfer with nothing pending: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want     = expected_status.pop_front();
                exp_word = {1'b0, want};
                for (int f = 0; f < 8; f++)
                begin
                    lo    = (f < 7) ? 5 * f : 31;
                    fmask = (f < 6) ? 5'h1f : 5'h01;
                    if (((exp_word >> lo) & fmask) != ((m_axis_tdata >> lo) & fmask))
                    begin
                        $error("%s: expected %h, got %h", names[f],
                               (exp_word >> lo) & fmask, (m_axis_tdata >> lo) & fmask);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_CYCLES)
        begin
            $display("watchdog: no transfer for %0d cycles", stall_cycles);
            $display("** dispenser_channel_jam_empty_monitor_core: FAILED **");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_request_types();
        test_channel_faults();
        test_random_limits();
        test_limit_extremes();
        test_output_stall();
        test_drain_pause();
        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** dispenser_channel_jam_empty_monitor_core: PASSED **");
        else
            $display("** dispenser_channel_jam_empty_monitor_core: FAILED **");
        $finish;
    end

endmodule
